>>> rtl/twrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrs_pkg
// Shared types, register codes and the HHMM split for the relay schedule unit.
// ----------------------------------------------------------------------------
package twrs_pkg;

    // Field widths.
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int TimeW   = 13;
    localparam int SplitHW = 6;   // hour part of a 12-bit HHMM value, up to 40
    localparam int SplitMW = 7;   // minute part, up to 99
    localparam int CfgAddrW = 5;
    localparam int CfgDataW = 32;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_OVERRIDE  = 3'd0;
    localparam logic [2:0] REG_SCHEDULE  = 3'd1;
    localparam logic [2:0] REG_CUST_ON   = 3'd2;
    localparam logic [2:0] REG_CUST_OFF  = 3'd3;
    localparam logic [2:0] REG_LONG_ON   = 3'd4;
    localparam logic [2:0] REG_LONG_OFF  = 3'd5;
    localparam logic [2:0] REG_SHORT_ON  = 3'd6;
    localparam logic [2:0] REG_SHORT_OFF = 3'd7;

    // Override codes.
    localparam logic [1:0] OVR_FOLLOW = 2'd0;
    localparam logic [1:0] OVR_OFF    = 2'd1;
    localparam logic [1:0] OVR_ON     = 2'd2;

    // Schedule codes.
    localparam logic [2:0] SCHED_ALWAYS_ON  = 3'd0;
    localparam logic [2:0] SCHED_LONG_DAY   = 3'd1;
    localparam logic [2:0] SCHED_SHORT_DAY  = 3'd2;
    localparam logic [2:0] SCHED_ALWAYS_OFF = 3'd3;
    localparam logic [2:0] SCHED_CUSTOM     = 3'd4;

    // Reset values.
    localparam logic [1:0]       RST_OVERRIDE  = OVR_FOLLOW;
    localparam logic [2:0]       RST_SCHEDULE  = SCHED_ALWAYS_OFF;
    localparam logic [TimeW-1:0] RST_CUST_ON   = 13'h1FFF;
    localparam logic [TimeW-1:0] RST_CUST_OFF  = 13'h1FFF;
    localparam logic [TimeW-1:0] RST_LONG_ON   = 13'd600;
    localparam logic [TimeW-1:0] RST_LONG_OFF  = 13'd0;
    localparam logic [TimeW-1:0] RST_SHORT_ON  = 13'd600;
    localparam logic [TimeW-1:0] RST_SHORT_OFF = 13'd1800;

    // Division by 100 through a reciprocal: floor(v * 5243 / 2^19) is exact
    // for every 12-bit v.
    localparam logic [12:0] RecipHundred = 13'd5243;
    localparam int          RecipShift   = 19;

    // One on/off window, already split into hours and minutes.
    typedef struct packed {
        logic               always_on;  // a negative time or equal times
        logic               on_lt_off;  // on time is earlier than off time
        logic [SplitHW-1:0] on_hr;
        logic [SplitMW-1:0] on_mn;
        logic [SplitHW-1:0] off_hr;
        logic [SplitMW-1:0] off_mn;
    } t_window;

    // Schedule settings seen by the decision logic.
    typedef struct packed {
        logic [1:0] override_mode;
        logic [2:0] schedule_mode;
        t_window    win_long;
        t_window    win_short;
        t_window    win_custom;
    } t_sched_cfg;

    // Split a non-negative HHMM value into hour and minute.
    function automatic logic [SplitHW+SplitMW-1:0] split_time(input logic [11:0] v);
        logic [24:0]        prod;
        logic [SplitHW-1:0] q;
        logic [12:0]        q_x100;
        logic [12:0]        rem;
        prod   = {13'd0, v} * {12'd0, RecipHundred};
        q      = prod[RecipShift +: SplitHW];
        q_x100 = ({7'd0, q} << 6) + ({7'd0, q} << 5) + ({7'd0, q} << 2);
        rem    = {1'b0, v} - q_x100;
        return {q, rem[SplitMW-1:0]};
    endfunction

    // Build a window from its two raw register values.
    function automatic t_window make_window(input logic [TimeW-1:0] on_t,
                                            input logic [TimeW-1:0] off_t);
        t_window w;
        logic [SplitHW+SplitMW-1:0] s_on;
        logic [SplitHW+SplitMW-1:0] s_off;
        s_on  = split_time(on_t[11:0]);
        s_off = split_time(off_t[11:0]);
        w.always_on = on_t[TimeW-1] | off_t[TimeW-1] | (on_t == off_t);
        w.on_lt_off = on_t[11:0] < off_t[11:0];
        w.on_hr     = s_on[SplitMW +: SplitHW];
        w.on_mn     = s_on[SplitMW-1:0];
        w.off_hr    = s_off[SplitMW +: SplitHW];
        w.off_mn    = s_off[SplitMW-1:0];
        return w;
    endfunction

endpackage

>>> rtl/time_window_relay_schedule_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_relay_schedule_unit
// Time-of-day relay control: each time of day yields one relay on/off flag
// from an override, a schedule mode and on/off windows that may wrap midnight.
//
//   Port group  Direction  Payload
//   s_axis      in         tdata[4:0] hour_now, tdata[10:5] minute_now
//   m_axis      out        tdata[0] relay_on
//   APB         in/out     8 registers at byte address 4*i, 32-bit data
//
// One transaction per clock in steady state while m_axis_tready is high; each
// input passes through an input register and then a result register.
// The input register, when empty, accepts a new item while a result waits.
// Window times are split into hour and minute in the cycle after a write.
// Reset is synchronous and active low, and empties both pipeline registers.
// ----------------------------------------------------------------------------
module time_window_relay_schedule_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // hour_now, minute_now
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // relay_on
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twrs_pkg::CfgAddrW-1:0] paddr,
    input  logic [twrs_pkg::CfgDataW-1:0] pwdata,
    output logic [twrs_pkg::CfgDataW-1:0] prdata,
    output logic                          pready
);
    import twrs_pkg::*;

    t_sched_cfg cfg;

    logic               r_in_valid;
    logic [HourW-1:0]   r_hour;
    logic [MinuteW-1:0] r_minute;
    logic               r_out_valid;
    logic               r_relay_on;
    logic               relay_on;
    logic               out_free;

    twrs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    twrs_decide u_decide (
        .i_cfg      (cfg),
        .i_hour     (r_hour),
        .i_minute   (r_minute),
        .o_relay_on (relay_on)
    );

    // Pipeline flow control.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_hour   <= s_axis_tdata[HourW-1:0];
            r_minute <= s_axis_tdata[HourW +: MinuteW];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_relay_on <= relay_on;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_relay_on};

endmodule

>>> rtl/twrs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrs_cfg_regs
// Register file behind the APB port, with the windows split into hours and
// minutes and registered in the cycle after each register update.
// ----------------------------------------------------------------------------
module twrs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twrs_pkg::CfgAddrW-1:0] paddr,
    input  logic [twrs_pkg::CfgDataW-1:0] pwdata,
    output logic [twrs_pkg::CfgDataW-1:0] prdata,
    output logic                          pready,
    output twrs_pkg::t_sched_cfg          o_cfg
);
    import twrs_pkg::*;

    logic [1:0]       r_override;
    logic [2:0]       r_schedule;
    logic [TimeW-1:0] r_cust_on;
    logic [TimeW-1:0] r_cust_off;
    logic [TimeW-1:0] r_long_on;
    logic [TimeW-1:0] r_long_off;
    logic [TimeW-1:0] r_short_on;
    logic [TimeW-1:0] r_short_off;

    t_window r_win_long;
    t_window r_win_short;
    t_window r_win_custom;
    t_window n_win_long;
    t_window n_win_short;
    t_window n_win_custom;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override  <= RST_OVERRIDE;
            r_schedule  <= RST_SCHEDULE;
            r_cust_on   <= RST_CUST_ON;
            r_cust_off  <= RST_CUST_OFF;
            r_long_on   <= RST_LONG_ON;
            r_long_off  <= RST_LONG_OFF;
            r_short_on  <= RST_SHORT_ON;
            r_short_off <= RST_SHORT_OFF;
        end else if (wr_en) begin
            case (reg_idx)
                REG_OVERRIDE:  r_override  <= pwdata[1:0];
                REG_SCHEDULE:  r_schedule  <= pwdata[2:0];
                REG_CUST_ON:   r_cust_on   <= pwdata[TimeW-1:0];
                REG_CUST_OFF:  r_cust_off  <= pwdata[TimeW-1:0];
                REG_LONG_ON:   r_long_on   <= pwdata[TimeW-1:0];
                REG_LONG_OFF:  r_long_off  <= pwdata[TimeW-1:0];
                REG_SHORT_ON:  r_short_on  <= pwdata[TimeW-1:0];
                REG_SHORT_OFF: r_short_off <= pwdata[TimeW-1:0];
                default: ;
            endcase
        end
    end

    // Read back, time registers sign-extended.
    always_comb begin
        case (reg_idx)
            REG_OVERRIDE:  prdata = {30'd0, r_override};
            REG_SCHEDULE:  prdata = {29'd0, r_schedule};
            REG_CUST_ON:   prdata = {{(CfgDataW-TimeW){r_cust_on[TimeW-1]}}, r_cust_on};
            REG_CUST_OFF:  prdata = {{(CfgDataW-TimeW){r_cust_off[TimeW-1]}}, r_cust_off};
            REG_LONG_ON:   prdata = {{(CfgDataW-TimeW){r_long_on[TimeW-1]}}, r_long_on};
            REG_LONG_OFF:  prdata = {{(CfgDataW-TimeW){r_long_off[TimeW-1]}}, r_long_off};
            REG_SHORT_ON:  prdata = {{(CfgDataW-TimeW){r_short_on[TimeW-1]}}, r_short_on};
            REG_SHORT_OFF: prdata = {{(CfgDataW-TimeW){r_short_off[TimeW-1]}}, r_short_off};
            default:       prdata = '0;
        endcase
    end

    // Split each window; the registered result follows the raw registers in the next cycle.
    always_comb begin
        n_win_long   = make_window(r_long_on, r_long_off);
        n_win_short  = make_window(r_short_on, r_short_off);
        n_win_custom = make_window(r_cust_on, r_cust_off);
    end

    always_ff @(posedge i_clk) begin
        r_win_long   <= n_win_long;
        r_win_short  <= n_win_short;
        r_win_custom <= n_win_custom;
    end

    assign o_cfg.override_mode = r_override;
    assign o_cfg.schedule_mode = r_schedule;
    assign o_cfg.win_long      = r_win_long;
    assign o_cfg.win_short     = r_win_short;
    assign o_cfg.win_custom    = r_win_custom;

endmodule

>>> rtl/twrs_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrs_decide
// Relay decision for one time of day from the override, the schedule mode and
// the selected on/off window.
// ----------------------------------------------------------------------------
module twrs_decide (
    input  twrs_pkg::t_sched_cfg         i_cfg,
    input  logic [twrs_pkg::HourW-1:0]   i_hour,
    input  logic [twrs_pkg::MinuteW-1:0] i_minute,
    output logic                         o_relay_on
);
    import twrs_pkg::*;

    t_window            win;
    logic               win_valid;
    logic               win_on;
    logic [SplitHW-1:0] hr;
    logic [SplitMW-1:0] mn;

    assign hr = {{(SplitHW-HourW){1'b0}}, i_hour};
    assign mn = {{(SplitMW-MinuteW){1'b0}}, i_minute};

    // Window selection by schedule mode.
    always_comb begin
        win       = i_cfg.win_custom;
        win_valid = 1'b0;
        case (i_cfg.schedule_mode)
            SCHED_LONG_DAY: begin
                win       = i_cfg.win_long;
                win_valid = 1'b1;
            end
            SCHED_SHORT_DAY: begin
                win       = i_cfg.win_short;
                win_valid = 1'b1;
            end
            SCHED_CUSTOM: begin
                win       = i_cfg.win_custom;
                win_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Window test: always on, within one hour, wrapping inside one hour, spanning
    // hours forward, or wrapping past midnight.
    always_comb begin
        if (win.always_on) begin
            win_on = 1'b1;
        end else if (win.on_hr == win.off_hr && win.on_mn < win.off_mn) begin
            win_on = (hr == win.on_hr) && (mn >= win.on_mn) && (mn <= win.off_mn);
        end else if (win.on_hr == win.off_hr) begin
            win_on = (hr != win.on_hr) || (mn >= win.on_mn) || (mn <= win.off_mn);
        end else if ((hr == win.on_hr && mn >= win.on_mn) ||
                     (hr == win.off_hr && mn < win.off_mn)) begin
            win_on = 1'b1;
        end else if (win.on_lt_off) begin
            win_on = (hr > win.on_hr) && (hr < win.off_hr);
        end else begin
            win_on = (hr > win.on_hr) || (hr < win.off_hr);
        end
    end

    // Override first, then the fixed schedule modes and the selected window.
    always_comb begin
        case (i_cfg.override_mode)
            OVR_OFF: o_relay_on = 1'b0;
            OVR_ON:  o_relay_on = 1'b1;
            default: begin
                if (i_cfg.schedule_mode == SCHED_ALWAYS_ON) begin
                    o_relay_on = 1'b1;
                end else begin
                    o_relay_on = win_valid & win_on;
                end
            end
        endcase
    end

endmodule
